// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is active
`define ISCE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also holds through reset
`define ISCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/isce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package isce_pkg;

    localparam int WORD_W            = 15;
    localparam int ICON_COUNT        = 8;
    localparam int ICON_IDX_W        = $clog2(ICON_COUNT);
    localparam int VOLUME_SEGMENTS   = 14;
    localparam int STRENGTH_SEGMENTS = 3;
    localparam int VOL_LSB           = 8;
    localparam int VOL_W             = 5;
    localparam int STR_LSB           = 13;
    localparam int STR_W             = 2;
    localparam int CODE_W            = 5;

    localparam int TOTAL_SLOTS = ICON_COUNT + VOLUME_SEGMENTS + STRENGTH_SEGMENTS;
    localparam int SLOT_W      = $clog2(TOTAL_SLOTS);

    localparam logic [SLOT_W-1:0] VOL_FIRST = SLOT_W'(ICON_COUNT);
    localparam logic [SLOT_W-1:0] STR_FIRST = SLOT_W'(ICON_COUNT + VOLUME_SEGMENTS);
    localparam logic [SLOT_W-1:0] VOL_LAST  = SLOT_W'(ICON_COUNT + VOLUME_SEGMENTS - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TOTAL_SLOTS - 1);

    localparam logic [CODE_W-1:0] VOLUME_BASE_CODE   = 5'h0B;
    localparam logic [CODE_W-1:0] STRENGTH_BASE_CODE = 5'h07;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    typedef enum logic [1:0] {
        SYM_OFF  = 2'd0,
        SYM_ON   = 2'd1,
        SYM_FULL = 2'd2
    } sym_state_t;

    typedef enum logic [1:0] {
        GRP_ICON     = 2'd0,
        GRP_VOLUME   = 2'd1,
        GRP_STRENGTH = 2'd2
    } group_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        sym_state_t        state;
        group_t            group;
    } cmd_t;

    typedef struct packed {
        logic fire;
        logic last;
    } slot_ctl_t;

    function automatic logic [CODE_W-1:0] icon_code(input logic [ICON_IDX_W-1:0] idx);
        logic [CODE_W-1:0] code;
        unique case (idx)
            3'd7:    code = 5'h0A;
            default: code = CODE_W'(idx);
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/isce_step_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// one command per slot: the shared compare works out the segment state
module isce_step_unit (
    input  wire logic [isce_pkg::SLOT_W-1:0] slot,
    input  wire logic [isce_pkg::WORD_W-1:0] word,
    output isce_pkg::cmd_t                   cmd
);

    logic [isce_pkg::VOL_W-1:0]      vol;
    logic [isce_pkg::STR_W-1:0]      str;
    logic [isce_pkg::SLOT_W-1:0]     seg;
    logic [isce_pkg::SLOT_W-1:0]     limit;
    logic [isce_pkg::ICON_IDX_W-1:0] icon_idx;
    logic                            seg_lt;
    logic                            seg_eq;

    assign vol      = word[isce_pkg::VOL_LSB +: isce_pkg::VOL_W];
    assign str      = word[isce_pkg::STR_LSB +: isce_pkg::STR_W];
    assign icon_idx = slot[isce_pkg::ICON_IDX_W-1:0];

    // segment index and the bound it is compared to
    always_comb begin
        priority if (slot < isce_pkg::STR_FIRST) begin
            seg   = slot - isce_pkg::VOL_FIRST;
            limit = isce_pkg::SLOT_W'(vol[isce_pkg::VOL_W-1:1]);
        end else begin
            seg   = slot - isce_pkg::STR_FIRST;
            limit = isce_pkg::SLOT_W'(str);
        end
    end

    assign seg_lt = seg < limit;
    assign seg_eq = seg == limit;

    always_comb begin
        priority if (slot < isce_pkg::VOL_FIRST) begin
            cmd.code  = isce_pkg::icon_code(icon_idx);
            cmd.state = word[icon_idx] ? isce_pkg::SYM_ON : isce_pkg::SYM_OFF;
            cmd.group = isce_pkg::GRP_ICON;
        end else if (slot < isce_pkg::STR_FIRST) begin
            cmd.code  = isce_pkg::VOLUME_BASE_CODE + isce_pkg::CODE_W'(seg);
            // below half: full, at half: dimmed when volume is odd
            if (seg_lt) begin
                cmd.state = isce_pkg::SYM_FULL;
            end else if (seg_eq && vol[0]) begin
                cmd.state = isce_pkg::SYM_ON;
            end else begin
                cmd.state = isce_pkg::SYM_OFF;
            end
            cmd.group = isce_pkg::GRP_VOLUME;
        end else begin
            cmd.code  = isce_pkg::STRENGTH_BASE_CODE + isce_pkg::CODE_W'(seg);
            cmd.state = seg_lt ? isce_pkg::SYM_ON : isce_pkg::SYM_OFF;
            cmd.group = isce_pkg::GRP_STRENGTH;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/isce_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

// walks all command slots of one item, one slot per cycle unless a slot with a command waits on a stalled output
module isce_seq (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [isce_pkg::WORD_W-1:0] s_indicator_word,
    input  wire logic                        out_free,
    output logic [isce_pkg::SLOT_W-1:0]      slot,
    output logic [isce_pkg::WORD_W-1:0]      word,
    output isce_pkg::slot_ctl_t              ctl
);

    isce_pkg::seq_state_t state_reg, state_next;
    logic [isce_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [isce_pkg::WORD_W-1:0]     word_reg, word_next;
    logic [isce_pkg::ICON_COUNT-1:0] diff_reg, diff_next;
    logic                            vol_chg_reg, vol_chg_next;
    logic                            str_chg_reg, str_chg_next;

    logic [isce_pkg::WORD_W-1:0]     diff_word;
    logic [isce_pkg::ICON_IDX_W-1:0] icon_idx;
    logic                            later_icons;
    logic                            enable;
    logic                            last;

    assign diff_word = s_indicator_word ^ word_reg;
    assign icon_idx  = slot_reg[isce_pkg::ICON_IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= isce_pkg::ST_IDLE;
            word_reg  <= '0;
        end else begin
            state_reg <= state_next;
            word_reg  <= word_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg    <= slot_next;
        diff_reg    <= diff_next;
        vol_chg_reg <= vol_chg_next;
        str_chg_reg <= str_chg_next;
    end

    // any changed icon above the current one
    always_comb begin
        later_icons = 1'b0;
        for (int k = 0; k < isce_pkg::ICON_COUNT; k++) begin
            if (diff_reg[k] && (isce_pkg::ICON_IDX_W'(k) > icon_idx)) begin
                later_icons = 1'b1;
            end
        end
    end

    always_comb begin
        priority if (slot_reg < isce_pkg::VOL_FIRST) begin
            enable = diff_reg[icon_idx];
            last   = !later_icons && !vol_chg_reg && !str_chg_reg;
        end else if (slot_reg < isce_pkg::STR_FIRST) begin
            enable = vol_chg_reg;
            last   = (slot_reg == isce_pkg::VOL_LAST) && !str_chg_reg;
        end else begin
            enable = str_chg_reg;
            last   = slot_reg == isce_pkg::LAST_SLOT;
        end
    end

    always_comb begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        word_next    = word_reg;
        diff_next    = diff_reg;
        vol_chg_next = vol_chg_reg;
        str_chg_next = str_chg_reg;
        s_ready      = 1'b0;
        ctl.fire     = 1'b0;
        ctl.last     = last;
        unique case (state_reg)
            isce_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    diff_next    = diff_word[isce_pkg::ICON_COUNT-1:0];
                    vol_chg_next = |diff_word[isce_pkg::VOL_LSB +: isce_pkg::VOL_W];
                    str_chg_next = |diff_word[isce_pkg::STR_LSB +: isce_pkg::STR_W];
                    word_next    = s_indicator_word;
                    slot_next    = '0;
                    state_next   = isce_pkg::ST_RUN;
                end
            end
            isce_pkg::ST_RUN: begin
                // hold the slot while its command cannot be registered
                if (!enable || out_free) begin
                    ctl.fire = enable;
                    if (slot_reg == isce_pkg::LAST_SLOT) begin
                        state_next = isce_pkg::ST_IDLE;
                    end else begin
                        slot_next = slot_reg + isce_pkg::SLOT_W'(1);
                    end
                end
            end
            default: begin
                state_next = isce_pkg::ST_IDLE;
            end
        endcase
    end

    assign slot = slot_reg;
    assign word = word_reg;

endmodule

`default_nettype wire

// ===== hdl/icon_state_change_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Indicator change encoder.
// Input channel (s_valid/s_ready, s_indicator_word): one 15-bit indicator word per item.
// Output channel (m_valid/m_ready, m_symbol_code, m_symbol_state, m_command_group,
// m_last_of_run): one set-symbol command per item, in order: changed icons, then the
// full volume bar if volume changed, then the strength segments if strength changed.
// m_last_of_run marks the final command of an input word; an unchanged word gives none.
// After an input is accepted, each of the 25 command slots is walked in turn
// by the sequencer through the shared segment compare unit.
// s_ready is high only between items. A command is registered and valid in the cycle
// after its slot is walked; a slot with nothing to report is still walked and
// sends nothing, so commands may come with gaps.
// A stalled receiver holds the output register; the sequencer then waits on the
// slot that has a command, so the item takes longer by the stalled cycles.
// Reset clears the stored word to zero and empties the output register.
module icon_state_change_encoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [14:0] s_indicator_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_symbol_code,
    output logic [1:0]       m_symbol_state,
    output logic [1:0]       m_command_group,
    output logic             m_last_of_run
);

    logic [isce_pkg::SLOT_W-1:0] slot;
    logic [isce_pkg::WORD_W-1:0] word;
    isce_pkg::slot_ctl_t         ctl;
    isce_pkg::cmd_t              cmd;
    logic                        out_free;

    logic                        m_valid_reg, m_valid_next;
    isce_pkg::cmd_t              cmd_reg;
    logic                        last_reg;

    assign out_free = !m_valid_reg || m_ready;

    isce_seq u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_indicator_word (s_indicator_word),
        .out_free         (out_free),
        .slot             (slot),
        .word             (word),
        .ctl              (ctl)
    );

    isce_step_unit u_step (
        .slot (slot),
        .word (word),
        .cmd  (cmd)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl.fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.fire) begin
            cmd_reg  <= cmd;
            last_reg <= ctl.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_symbol_code   = cmd_reg.code;
    assign m_symbol_state  = cmd_reg.state;
    assign m_command_group = cmd_reg.group;
    assign m_last_of_run   = last_reg;

endmodule

`default_nettype wire

// ===== hdl/isce_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module isce_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [14:0] s_indicator_word,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [4:0]  m_symbol_code,
    input wire logic [1:0]  m_symbol_state,
    input wire logic [1:0]  m_command_group,
    input wire logic        m_last_of_run
);

    logic unused_ok;
    assign unused_ok = ^{s_indicator_word, m_symbol_state, m_command_group, m_last_of_run};

    `ISCE_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid, "output valid after reset")

    `ISCE_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "ready right after an item")

    `ISCE_ASSERT(a_result_from_busy, aclk, aresetn, $rose(m_valid) |-> !$past(s_ready), "result appeared while idle")

    `ISCE_ASSERT(a_valid_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped while stalled")

    `ISCE_ASSERT(a_code_holds, aclk, aresetn, m_valid && !m_ready |=> $stable(m_symbol_code), "result changed while stalled")

endmodule

bind icon_state_change_encoder isce_checker u_isce_checker (.*);

`default_nettype wire
